[hdl/sorted_list_insert_delete_defines.svh]
// ----------------------------------------------------------------------------
// Sorted list assertion macros
// Shared assertion shorthands for the sorted key list block.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SLI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define SLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sli_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted list package
// Field widths, operation and status codes, and transaction payload types.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int KEY_W        = 32;
  localparam int IDX_W        = 7;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int DEPTH_DEFAULT = 64;
  localparam logic [IDX_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [KEY_W-1:0] key;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        end_index;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] read_key;
    logic [IDX_W-1:0]        count;
    logic [STATUS_W-1:0]     status;
  } out_item_t;

endpackage

[hdl/sorted_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// Sorted key list
// Ordered store of signed fixed-point keys with insert, range delete and read.
// ----------------------------------------------------------------------------
// The block keeps up to min(capacity_limit, DEPTH) signed Q16.16 keys in
// ascending order in a single memory with one write and one registered read
// port, and serves one transaction at a time. An insert runs a binary search
// through the memory with at most ceil(log2(count+1)) probes, then moves
// each later entry up by one at one entry per cycle, and finally stores the
// key. A delete moves the entries behind the removed range down at one per
// cycle. Every search probe and every move goes through the one memory read
// port, and the search uses the single key comparator. A finished result
// waits until the output register is free or being emptied. A new transaction
// is taken as soon as the previous result sits in the output register, even
// if that result has not yet been taken.
// Equal keys are inserted before the existing equal keys. An insert into a
// full list, a delete range beyond the count and a read beyond the count
// change nothing and report a status code. There is no clearing pass after
// reset: only entries below the count are ever read, and those were written.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete
  import sli_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration write channel: capacity_limit.
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_data_i,
  // Operation channel.
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  // Result channel.
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o
);

  `include "sorted_list_insert_delete_defines.svh"

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // One-hot sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SRCH_RD  = 7'b0000010,
    ST_SRCH_CMP = 7'b0000100,
    ST_MOVE     = 7'b0001000,
    ST_PLACE    = 7'b0010000,
    ST_RD_WAIT  = 7'b0100000,
    ST_DONE     = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Control state.
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] cap_q;
  logic             out_valid_q;
  logic             pend_q;

  // Datapath registers of the transaction in flight.
  logic signed [KEY_W-1:0] key_q;
  logic                    ins_q;      // move direction: up for insert, down for delete
  logic [CNT_W-1:0]        lo_q;
  logic [CNT_W-1:0]        hi_q;
  logic [ADDR_W-1:0]       mid_q;
  logic [ADDR_W-1:0]       pos_q;
  logic [CNT_W-1:0]        src_q;
  logic [CNT_W-1:0]        rem_q;
  logic [CNT_W-1:0]        n_q;
  logic [ADDR_W-1:0]       wdst_q;
  logic signed [KEY_W-1:0] res_key_q;
  logic [STATUS_W-1:0]     res_status_q;
  out_item_t               out_q;

  // Memory and its ports.
  logic signed [KEY_W-1:0] mem_q [DEPTH];
  logic signed [KEY_W-1:0] rdata_q;
  logic                    mem_re;
  logic [ADDR_W-1:0]       mem_raddr;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic signed [KEY_W-1:0] mem_wdata;

  // Shared helpers.
  logic              accept;
  logic              out_load;
  logic [CMP_W-1:0]  cnt_x;
  logic [CMP_W-1:0]  first_x;
  logic [CMP_W-1:0]  end_x;
  logic              list_full;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid_full;
  logic              key_lt;
  logic [CNT_W-1:0]  move_dst;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign cnt_x     = CMP_W'(cnt_q);
  assign first_x   = CMP_W'(in_data_i.first_index);
  assign end_x     = CMP_W'(in_data_i.end_index);
  assign list_full = (cnt_x >= CMP_W'(cap_q)) || (cnt_x >= CMP_W'(DEPTH));

  // Search midpoint and the single key comparator.
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_full = mid_sum[CNT_W:1];
  assign key_lt   = (rdata_q < key_q);

  // Destination of the entry now being read during a move.
  assign move_dst = ins_q ? (src_q + 1'b1) : (src_q - n_q);

  // Memory port control.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = wdst_q;
    mem_wdata = rdata_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_data_i.mode == MODE_READ)) begin
          mem_re    = 1'b1;
          mem_raddr = first_x[ADDR_W-1:0];
        end
      end
      ST_SRCH_RD: begin
        mem_re    = (lo_q < hi_q);
        mem_raddr = mid_full[ADDR_W-1:0];
      end
      ST_MOVE: begin
        mem_re    = (rem_q != '0);
        mem_raddr = src_q[ADDR_W-1:0];
        mem_we    = pend_q;
      end
      ST_PLACE: begin
        mem_we    = ins_q;
        mem_waddr = pos_q;
        mem_wdata = key_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.mode)
            MODE_INSERT: state_d = list_full ? ST_DONE : ST_SRCH_RD;
            MODE_DELETE: begin
              if (first_x >= end_x || end_x > cnt_x) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_MOVE;
              end
            end
            MODE_READ:   state_d = (first_x >= cnt_x) ? ST_DONE : ST_RD_WAIT;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_SRCH_RD:  state_d = (lo_q < hi_q) ? ST_SRCH_CMP : ST_MOVE;
      ST_SRCH_CMP: state_d = ST_SRCH_RD;
      ST_MOVE: begin
        if (rem_q == '0 && !pend_q) begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE:    state_d = ST_DONE;
      ST_RD_WAIT:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_MOVE) begin
        pend_q <= (rem_q != '0);
      end else begin
        pend_q <= 1'b0;
      end
      if (state_q == ST_PLACE) begin
        cnt_q <= ins_q ? (cnt_q + 1'b1) : (cnt_q - n_q);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_q        <= in_data_i.key;
          ins_q        <= (in_data_i.mode == MODE_INSERT);
          lo_q         <= '0;
          hi_q         <= cnt_q;
          res_key_q    <= '0;
          res_status_q <= STATUS_OK;
          // Delete setup; the insert overwrites src and rem after its search.
          n_q          <= CNT_W'(end_x - first_x);
          src_q        <= CNT_W'(end_x);
          rem_q        <= cnt_q - CNT_W'(end_x);
          case (in_data_i.mode)
            MODE_INSERT: begin
              if (list_full) begin
                res_status_q <= STATUS_FULL;
              end
            end
            MODE_DELETE: begin
              if (first_x < end_x && end_x > cnt_x) begin
                res_status_q <= STATUS_RANGE;
              end
            end
            MODE_READ: begin
              if (first_x >= cnt_x) begin
                res_status_q <= STATUS_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SRCH_RD: begin
        if (lo_q < hi_q) begin
          mid_q <= mid_full[ADDR_W-1:0];
        end else begin
          // Search done: lo is the leftmost entry not less than the key.
          pos_q <= lo_q[ADDR_W-1:0];
          src_q <= cnt_q - 1'b1;
          rem_q <= cnt_q - lo_q;
        end
      end
      ST_SRCH_CMP: begin
        if (key_lt) begin
          lo_q <= CNT_W'(mid_q) + 1'b1;
        end else begin
          hi_q <= CNT_W'(mid_q);
        end
      end
      ST_MOVE: begin
        if (rem_q != '0) begin
          wdst_q <= move_dst[ADDR_W-1:0];
          src_q  <= ins_q ? (src_q - 1'b1) : (src_q + 1'b1);
          rem_q  <= rem_q - 1'b1;
        end
      end
      ST_RD_WAIT: begin
        res_key_q <= rdata_q;
      end
      ST_DONE: begin
        if (out_load) begin
          out_q.read_key <= res_key_q;
          out_q.count    <= IDX_W'(cnt_q);
          out_q.status   <= res_status_q;
        end
      end
      default: begin
      end
    endcase
  end

  // A move never reads the entry it writes in the same cycle.
  `SLI_ASSERT(a_move_no_overlap, clk_i, rst_ni,
              !(mem_we && mem_re && (state_q == ST_MOVE)) || (mem_waddr != mem_raddr),
              "move reads and writes the same entry")
  // A completed insert grows the list by exactly one entry.
  `SLI_ASSERT_NEXT(a_insert_grows, clk_i, rst_ni, (state_q == ST_PLACE) && ins_q,
                   cnt_q == $past(cnt_q) + 1'b1, "insert did not add one entry")
  // Loads happen only when the output is free or emptying, and leave a result valid.
  `SLI_ASSERT_NEXT(a_out_load, clk_i, rst_ni, out_load,
                   out_valid_q && (state_q == ST_IDLE), "result load did not present a result")

endmodule

[dv/sorted_list_checker.sv]
// ----------------------------------------------------------------------------
// Sorted list checker
// Watches the configuration, operation and result channels of the sorted key
// list, predicts each result from its own copy of the list and compares.
// ----------------------------------------------------------------------------
module sorted_list_checker
  import sli_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [IDX_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_item_t         in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_item_t        out_data_i,
  output int               mismatch_count_o,
  output int               replies_due_o,
  output int               list_count_o
);

  logic signed [KEY_W-1:0] list_keys [DEPTH];
  int unsigned             list_len;
  logic [IDX_W-1:0]        capacity;
  out_item_t               replies_due [$];
  out_item_t               oldest_reply;

  // Applies one operation to the predicted list and returns its result.
  function automatic out_item_t apply_list_op(input in_item_t op);
    out_item_t   res;
    int unsigned usable, lo, hi, mid, span, i;
    res    = '0;
    usable = (capacity < DEPTH) ? capacity : DEPTH;
    case (op.mode)
      MODE_INSERT: begin
        if (list_len >= usable) begin
          res.status = STATUS_FULL;
        end else begin
          // Leftmost slot whose key is not below the new key.
          lo = 0;
          hi = list_len;
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if ($signed(list_keys[mid]) < $signed(op.key)) lo = mid + 1;
            else hi = mid;
          end
          for (i = list_len; i > lo; i--) list_keys[i] = list_keys[i-1];
          list_keys[lo] = op.key;
          list_len++;
        end
      end
      MODE_DELETE: begin
        if (op.first_index < op.end_index) begin
          if (op.end_index > list_len) begin
            res.status = STATUS_RANGE;
          end else begin
            span = op.end_index - op.first_index;
            for (i = op.end_index; i < list_len; i++) list_keys[i-span] = list_keys[i];
            list_len -= span;
          end
        end
      end
      MODE_READ: begin
        if (op.first_index >= list_len) res.status = STATUS_RANGE;
        else res.read_key = list_keys[op.first_index];
      end
      default: ;
    endcase
    res.count = IDX_W'(list_len);
    return res;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      capacity = CAP_RESET;
      replies_due.delete();
      mismatch_count_o = 0;
      replies_due_o    = 0;
      list_count_o     = 0;
    end else begin
      // Results leave before the operation taken at the same edge is predicted.
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual key %0d count %0d status %0d",
                   $time, out_data_i.read_key, out_data_i.count, out_data_i.status);
          mismatch_count_o++;
        end else begin
          oldest_reply = replies_due.pop_front();
          check_field("read_key", oldest_reply.read_key, out_data_i.read_key);
          check_field("count", oldest_reply.count, out_data_i.count);
          check_field("status", oldest_reply.status, out_data_i.status);
        end
      end
      if (cfg_valid_i && cfg_ready_i) capacity = cfg_data_i;
      if (in_valid_i && in_ready_i) replies_due.push_back(apply_list_op(in_data_i));
      replies_due_o = replies_due.size();
      list_count_o  = list_len;
    end
  end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// Sorted list testbench
// Drives directed and random insert, delete and read transactions through
// several capacity settings, with random idling on both sides and one long
// result hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  import sli_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 7;
  localparam int IDLE_PCT        = 22;
  localparam int NUM_PHASES      = 10;
  localparam int PHASE_ITEMS     = 170;
  localparam int FILL_ITEMS      = PHASE_ITEMS * 3 / 5;
  localparam int CALM_PHASE      = 3;
  localparam int HOLD_PHASE      = 0;
  localparam int HOLD_OFF_CYCLES = 400;
  // The longest operation is an insert at the front of a list one short of
  // full: a search plus 63 moves.
  localparam int SETTLE_CYCLES   = 100;
  localparam int LIMIT_CYCLES    = 800_000;

  // The fourth operation code is unused by the block and must change nothing.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;

  int mismatch_count;
  int replies_due;
  int list_count;

  // Idle percentages are changed by the stimulus process and read by the
  // sender and receiver; a calm phase sets both to zero.
  int in_idle_pct   = IDLE_PCT;
  int out_idle_pct  = IDLE_PCT;
  bit hold_off_req  = 1'b0;
  bit hold_off_done = 1'b0;

  int phase_caps [NUM_PHASES] = '{64, 1, 17, 64, 2, 127, 33, 0, 64, 5};

  sorted_list_insert_delete uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  sorted_list_checker list_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_data),
    .mismatch_count_o(mismatch_count),
    .replies_due_o   (replies_due),
    .list_count_o    (list_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // The run is cut off here if the block stops answering.
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic in_item_t make_op(input logic [MODE_W-1:0] mode,
                                       input logic [KEY_W-1:0] key,
                                       input int unsigned first_idx,
                                       input int unsigned stop_idx);
    in_item_t op;
    op.mode        = mode;
    op.key         = key;
    op.first_index = IDX_W'(first_idx);
    op.end_index   = IDX_W'(stop_idx);
    return op;
  endfunction

  // Offers one operation transaction and returns at the falling edge after it
  // is taken. Valid stays high past that point and drops only when the sender
  // idles at random before an offer; the caller lowers it before idle phases.
  task automatic send_op(input in_item_t op);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = op;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Waits until every result is back, then lets the block settle, so that a
  // register write lands while it is idle.
  task automatic drain_results();
    in_valid = 1'b0;
    while (replies_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [IDX_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result receiver: random stalls, plus one long hold-off while the sender
  // keeps offering, so the block fills up and pushes back on its input.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
      end
      out_ready = ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned      cnt, roll, first_idx, stop_idx, span, pick;
    int               ins_w, del_w, rd_w, ph, n, i;
    logic [KEY_W-1:0]  key;
    logic [MODE_W-1:0] mode;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part on a small list so that it fills after four inserts.
    write_capacity(7'd4);
    send_op(make_op(MODE_READ, '0, 0, 0));          // read of an empty list
    send_op(make_op(MODE_DELETE, '0, 0, 1));        // delete beyond the count
    send_op(make_op(MODE_DELETE, '0, 5, 2));        // empty range, first above end
    send_op(make_op(MODE_DELETE, '1, 127, 0));      // empty range at the index limits
    send_op(make_op(MODE_DELETE, '0, 0, 127));      // range ending far beyond the count
    send_op(make_op(MODE_INSERT, 32'h7FFF_FFFF, 0, 0));
    send_op(make_op(MODE_INSERT, 32'h8000_0000, 0, 0));
    send_op(make_op(MODE_INSERT, 32'h0001_0000, 0, 0));
    send_op(make_op(MODE_INSERT, 32'h0001_0000, 0, 0)); // equal key goes first
    send_op(make_op(MODE_INSERT, 32'hFFFF_FFFF, 0, 0)); // list is full
    for (i = 0; i <= 4; i++) send_op(make_op(MODE_READ, '0, i, 0));
    send_op(make_op(MODE_READ, '0, 127, 0));
    send_op(make_op(MODE_UNUSED, '1, 127, 127));
    send_op(make_op(MODE_DELETE, '0, 1, 3));
    send_op(make_op(MODE_DELETE, '0, 0, 0));
    send_op(make_op(MODE_DELETE, '0, 1, 2));
    drain_results();
    // A zero capacity refuses every insert, even with room left.
    write_capacity(7'd0);
    send_op(make_op(MODE_INSERT, '0, 0, 0));
    send_op(make_op(MODE_READ, '0, 0, 0));

    // Random phases. Each phase first leans on inserts to fill the list, then
    // on deletes and reads to drain it. Most deletes and reads use indices
    // inside the current count; the rest are random noise.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      write_capacity(IDX_W'(phase_caps[ph]));
      in_idle_pct  = (ph == CALM_PHASE) ? 0 : IDLE_PCT;
      out_idle_pct = (ph == CALM_PHASE) ? 0 : IDLE_PCT;
      if (ph == HOLD_PHASE) hold_off_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        cnt   = list_count;
        roll  = $urandom_range(99);
        ins_w = (n < FILL_ITEMS) ? 75 : 20;
        del_w = (n < FILL_ITEMS) ? 5 : 40;
        rd_w  = (n < FILL_ITEMS) ? 17 : 35;
        key       = $urandom;
        first_idx = $urandom_range(0, 127);
        stop_idx  = $urandom_range(0, 127);
        if (roll < ins_w) begin
          mode = MODE_INSERT;
          // A small pool of keys gives many equal keys, the extremes included.
          if ($urandom_range(99) < 40) begin
            pick = $urandom_range(0, 17);
            if (pick == 16) key = 32'h8000_0000;
            else if (pick == 17) key = 32'h7FFF_FFFF;
            else key = KEY_W'((int'(pick) - 8) * 65536);
          end
        end else if (roll < ins_w + del_w) begin
          mode = MODE_DELETE;
          if (cnt > 0 && $urandom_range(99) < 80) begin
            first_idx = $urandom_range(0, cnt - 1);
            span      = ($urandom_range(9) == 0) ? cnt - first_idx : $urandom_range(1, 3);
            stop_idx  = (first_idx + span > cnt) ? cnt : first_idx + span;
          end
        end else if (roll < ins_w + del_w + rd_w) begin
          mode = MODE_READ;
          if (cnt > 0 && $urandom_range(99) < 85) first_idx = $urandom_range(0, cnt - 1);
        end else begin
          mode = MODE_UNUSED;
        end
        send_op(make_op(mode, key, first_idx, stop_idx));
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/sli_pkg.sv
hdl/sorted_list_insert_delete.sv
dv/sorted_list_checker.sv
dv/tb.sv
